FILE: sv/spq_pkg.sv
// Shared types and codes for the sorted priority queue.
package spq_pkg;

   localparam int unsigned DATA_W  = 32;
   localparam int unsigned PRIO_W  = 32;
   localparam int unsigned COUNT_W = 5;
   localparam int unsigned ERR_W   = 2;

   // Operation codes
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   // Error codes
   localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
   localparam logic [ERR_W-1:0] ERR_POP_EMPTY = 2'd1;
   localparam logic [ERR_W-1:0] ERR_PUSH_FULL = 2'd2;

   // One stored entry
   typedef struct packed {
      logic              valid;
      logic [DATA_W-1:0] data;
      logic [PRIO_W-1:0] prio;
   } spq_slot_type;

   // What a cell hands to its right-hand neighbor
   typedef struct packed {
      spq_slot_type slot;
      logic         greater;
   } spq_link_type;

   // Command broadcast to every cell
   typedef struct packed {
      logic              push;
      logic              pop;
      logic [DATA_W-1:0] data;
      logic [PRIO_W-1:0] prio;
   } spq_cmd_type;

endpackage

FILE: sv/spq_channels.sv
// Request and response channel interfaces of the sorted priority queue.
interface spq_req_if;
   logic               valid;
   logic               ready;
   logic               op;
   logic signed [31:0] item_data;
   logic signed [31:0] item_priority;

   modport source (output valid, output op, output item_data, output item_priority,
                   input ready);
   modport sink   (input valid, input op, input item_data, input item_priority,
                   output ready);
endinterface

interface spq_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] head_data;
   logic               head_valid;
   logic        [4:0]  entry_count;
   logic        [1:0]  error_code;

   modport source (output valid, output head_data, output head_valid,
                   output entry_count, output error_code, input ready);
   modport sink   (input valid, input head_data, input head_valid,
                   input entry_count, input error_code, output ready);
endinterface

FILE: sv/spq_cell.sv
// One slot of the sorted shift-register queue.
module spq_cell
   import spq_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  spq_cmd_type  cmd,
   input  spq_link_type left_link,   // neighbor toward the head
   input  spq_slot_type right_slot,  // neighbor toward the tail
   output spq_link_type link,
   output spq_slot_type slot_in
);

   spq_slot_type slot_ff;
   logic         greater;
   logic         shift_in;
   logic         new_in;

   // Stored entry ranks behind the pushed one
   assign greater = slot_ff.valid && ($signed(slot_ff.prio) > $signed(cmd.prio));

   // Left neighbor moves right into us, or the new entry lands here
   assign shift_in = left_link.greater;
   assign new_in   = !shift_in && (greater || (!slot_ff.valid && left_link.slot.valid));

   // Next slot contents
   always_comb begin
      slot_in = slot_ff;
      if (cmd.pop) begin
         slot_in = right_slot;
      end else if (cmd.push) begin
         if (shift_in) begin
            slot_in = left_link.slot;
         end else if (new_in) begin
            slot_in.valid = 1'b1;
            slot_in.data  = cmd.data;
            slot_in.prio  = cmd.prio;
         end
      end
   end

   // Valid is control state; payload needs no reset
   always_ff @(posedge clock) begin
      slot_ff.data <= slot_in.data;
      slot_ff.prio <= slot_in.prio;
      if (reset) begin
         slot_ff.valid <= 1'b0;
      end else begin
         slot_ff.valid <= slot_in.valid;
      end
   end

   assign link.slot    = slot_ff;
   assign link.greater = greater;

endmodule

FILE: sv/sorted_priority_queue_unit.sv
// Sorted priority queue built as a row of QUEUE_DEPTH shift-register cells, head in
// cell 0. Every cell compares its priority with the pushed one in parallel and the
// row shifts as a whole, so a push or a pop transaction is taken every cycle while the
// response side does not stall, and its response (head after the operation, count,
// error) appears in the output register in the next cycle. Equal priorities leave
// first-in first-out. A push on a full queue is dropped with error 2, a pop on an empty
// queue does nothing and reports error 1. entry_count shows the low five bits of the count.
module sorted_priority_queue_unit
   import spq_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 16
) (
   input logic     clock,
   input logic     reset,
   spq_req_if.sink   req_chan,
   spq_rsp_if.source rsp_chan
);

   localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

   spq_link_type links [QUEUE_DEPTH+1];
   spq_slot_type tails [QUEUE_DEPTH+1];
   spq_slot_type head_in;
   spq_slot_type cell_next [QUEUE_DEPTH];
   spq_cmd_type  cmd;

   logic [CNT_W-1:0]   count_ff, count_in;
   logic [CNT_W+4:0]   count_wide;
   logic               accept;
   logic               is_full;
   logic               is_empty;
   logic [ERR_W-1:0]   err;

   logic               rsp_valid_ff;
   logic [DATA_W-1:0]  head_data_ff, head_data_in;
   logic               head_valid_ff;
   logic [COUNT_W-1:0] entry_count_ff, entry_count_in;
   logic [ERR_W-1:0]   error_code_ff;

   // Output register parts the two sides
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   assign is_full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign is_empty = (count_ff == '0);

   // Command for the cell row
   always_comb begin
      cmd.push = accept && (req_chan.op == OP_PUSH) && !is_full;
      cmd.pop  = accept && (req_chan.op == OP_POP) && !is_empty;
      cmd.data = req_chan.item_data;
      cmd.prio = req_chan.item_priority;
   end

   // Error code of the accepted transaction
   always_comb begin
      err = ERR_NONE;
      if (req_chan.op == OP_PUSH) begin
         if (is_full) err = ERR_PUSH_FULL;
      end else begin
         if (is_empty) err = ERR_POP_EMPTY;
      end
   end

   // Chain ends: an always-valid, never-greater left edge; an empty right edge
   assign links[0] = '{slot: '{valid: 1'b1, data: '0, prio: '0}, greater: 1'b0};
   assign tails[QUEUE_DEPTH] = '{valid: 1'b0, data: '0, prio: '0};

   // Cell row
   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      spq_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .left_link  (links[i]),
         .right_slot (tails[i+1]),
         .link       (links[i+1]),
         .slot_in    (cell_next[i])
      );
      assign tails[i] = links[i+1].slot;
   end

   assign head_in = cell_next[0];

   // Entry count
   always_comb begin
      count_in = count_ff;
      if (cmd.push) count_in = count_ff + CNT_W'(1);
      else if (cmd.pop) count_in = count_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Response contents
   assign count_wide     = {5'd0, count_in};
   assign entry_count_in = count_wide[COUNT_W-1:0];
   assign head_data_in   = head_in.valid ? head_in.data : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         head_data_ff   <= head_data_in;
         head_valid_ff  <= head_in.valid;
         entry_count_ff <= entry_count_in;
         error_code_ff  <= err;
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.head_data   = head_data_ff;
   assign rsp_chan.head_valid  = head_valid_ff;
   assign rsp_chan.entry_count = entry_count_ff;
   assign rsp_chan.error_code  = error_code_ff;

endmodule
